// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define CAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/cac_pkg.sv
package cac_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

endpackage

// File: hdl/cac_div_cell.sv
// One restoring-division step: brings down the next dividend bit, subtracts
// the divisor when it fits and shifts one quotient bit in.
module cac_div_cell #(
    parameter int DEN_W = 32,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [Q_W-1:0]   i_nlow,
    input  logic [Q_W-1:0]   i_q,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    input  logic             i_ovf,
    output logic [DEN_W-1:0] o_rem,
    output logic [Q_W-1:0]   o_nlow,
    output logic [Q_W-1:0]   o_q,
    output logic [DEN_W-1:0] o_den,
    output logic             o_neg,
    output logic             o_ovf
);

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W-1:0] w_rem;

    always_comb begin
        w_trial = {i_rem, i_nlow[Q_W-1]};
        w_ge    = w_trial >= {1'b0, i_den};
        w_rem   = w_ge ? DEN_W'(w_trial - {1'b0, i_den}) : DEN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_rem;
            o_nlow <= {i_nlow[Q_W-2:0], 1'b0};
            o_q    <= {i_q[Q_W-2:0], w_ge};
            o_den  <= i_den;
            o_neg  <= i_neg;
            o_ovf  <= i_ovf;
        end
    end

endmodule

// File: hdl/complex_arith_alu_unit.sv
// Channel  | Dir | Payload (lowest bits first)                    | Handshake
// s_axis   | in  | tdata: first_real, first_imag, second_real,   | tvalid/tready
//          |     |        second_imag; tuser: func               |
// m_axis   | out | tdata: result_real, result_imag; tuser: status | tvalid/tready
//
// One transaction per cycle sustained while s_axis_tready is high; the path is
// one multiplier stage, DATA_WIDTH divider cells and one output stage.
// The divider cell chain sets the latency; every op walks through it.
// Reset (i_rst_n low, synchronous) clears all valid bits.
// A stalled output is parked in a skid register; s_axis_tready drops only
// while that register is full.
module complex_arith_alu_unit #(
    parameter int DATA_WIDTH = cac_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = cac_pkg::DEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_real, first_imag, second_real, second_imag
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // func
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // result_real, result_imag
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // status
    output logic [1:0]                            m_axis_tuser
);

    import cac_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2*DW + 1;
    localparam int DENW = 2*DW;
    localparam int NW   = PW + FRAC_BITS;
    localparam int HW   = NW - DW;
    localparam int CW   = (HW > DENW) ? HW : DENW;
    localparam int OTW  = ((2*DW+7)/8)*8;

    typedef struct packed {
        logic          vld;
        logic          is_div;
        logic          dz;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        t_status       st;
    } t_side;

    function automatic logic [DW:0] sat_p(input logic signed [PW-1:0] v);
        logic ok;
        ok = (&v[PW-1:DW-1]) || !(|v[PW-1:DW-1]);
        if (ok) begin
            return {1'b0, v[DW-1:0]};
        end else if (v[PW-1]) begin
            return {1'b1, 1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // quotient magnitude plus sign to saturated two's complement
    function automatic logic [DW:0] sat_q(input logic [DW-1:0] q, input logic neg,
                                          input logic ovf);
        if (!neg) begin
            if (ovf || q[DW-1]) begin
                return {1'b1, 1'b0, {(DW-1){1'b1}}};
            end else begin
                return {1'b0, q};
            end
        end else if (ovf || (q[DW-1] && (|q[DW-2:0]))) begin
            return {1'b1, 1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, DW'(-q)};
        end
    endfunction

    logic                 w_en;
    logic                 w_acc;
    logic signed [DW-1:0] w_a, w_b, w_c, w_d;
    t_func                w_func;

    logic          r_p_vld, r_sk_vld;
    logic [DW-1:0] r_p_re, r_p_im, r_sk_re, r_sk_im;
    t_status       r_p_st, r_sk_st;

    assign w_en          = !r_sk_vld;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_a           = s_axis_tdata[DW-1:0];
    assign w_b           = s_axis_tdata[2*DW-1:DW];
    assign w_c           = s_axis_tdata[3*DW-1:2*DW];
    assign w_d           = s_axis_tdata[4*DW-1:3*DW];
    assign w_func        = t_func'(s_axis_tuser);

    // stage 1: products and per-part sums or differences
    logic                   r1_vld;
    t_func                  r1_func;
    logic signed [2*DW-1:0] r1_ac, r1_bd, r1_ad, r1_bc, r1_cc, r1_dd;
    logic signed [DW:0]     r1_sre, r1_sim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func <= w_func;
            r1_ac   <= w_a * w_c;
            r1_bd   <= w_b * w_d;
            r1_ad   <= w_a * w_d;
            r1_bc   <= w_b * w_c;
            r1_cc   <= w_c * w_c;
            r1_dd   <= w_d * w_d;
            if (w_func == FN_SUB) begin
                r1_sre <= {w_a[DW-1], w_a} - {w_c[DW-1], w_c};
                r1_sim <= {w_b[DW-1], w_b} - {w_d[DW-1], w_d};
            end else begin
                r1_sre <= {w_a[DW-1], w_a} + {w_c[DW-1], w_c};
                r1_sim <= {w_b[DW-1], w_b} + {w_d[DW-1], w_d};
            end
        end
    end

    // stage 2 inputs: add/sub/mul results, divider setup
    logic signed [PW-1:0] w_m_re, w_m_im, w_d_re, w_d_im;
    logic [PW-1:0]        w_mag_re, w_mag_im;
    logic [NW-1:0]        w_n_re, w_n_im;
    logic [DENW-1:0]      w_den;
    logic [DW:0]          w_sr, w_si;
    t_side                w_side;

    logic [DENW-1:0] w_rem_re [0:DW];
    logic [DENW-1:0] w_rem_im [0:DW];
    logic [DW-1:0]   w_nl_re  [0:DW];
    logic [DW-1:0]   w_nl_im  [0:DW];
    logic [DW-1:0]   w_q_re   [0:DW];
    logic [DW-1:0]   w_q_im   [0:DW];
    logic [DENW-1:0] w_den_re [0:DW];
    logic [DENW-1:0] w_den_im [0:DW];
    logic            w_neg_re [0:DW];
    logic            w_neg_im [0:DW];
    logic            w_ovf_re [0:DW];
    logic            w_ovf_im [0:DW];

    always_comb begin
        w_m_re   = PW'(r1_ac) - PW'(r1_bd);
        w_m_im   = PW'(r1_ad) + PW'(r1_bc);
        w_d_re   = PW'(r1_ac) + PW'(r1_bd);
        w_d_im   = PW'(r1_bc) - PW'(r1_ad);
        w_den    = DENW'($unsigned(r1_cc)) + DENW'($unsigned(r1_dd));
        w_mag_re = w_d_re[PW-1] ? PW'(-w_d_re) : PW'(w_d_re);
        w_mag_im = w_d_im[PW-1] ? PW'(-w_d_im) : PW'(w_d_im);
        w_n_re   = NW'(w_mag_re) << FRAC_BITS;
        w_n_im   = NW'(w_mag_im) << FRAC_BITS;

        case (r1_func)
            FN_MUL: begin
                w_sr = sat_p(w_m_re >>> FRAC_BITS);
                w_si = sat_p(w_m_im >>> FRAC_BITS);
            end
            default: begin
                w_sr = sat_p(PW'(r1_sre));
                w_si = sat_p(PW'(r1_sim));
            end
        endcase

        w_side.vld    = r1_vld;
        w_side.is_div = (r1_func == FN_DIV);
        w_side.dz     = (w_den == '0);
        w_side.re     = w_sr[DW-1:0];
        w_side.im     = w_si[DW-1:0];
        w_side.st     = (w_sr[DW] || w_si[DW]) ? ST_SAT : ST_OK;

        // high dividend part at or above the divisor means the quotient
        // has bits above DW and saturates anyway
        w_ovf_re[0] = CW'(w_n_re[NW-1:DW]) >= CW'(w_den);
        w_ovf_im[0] = CW'(w_n_im[NW-1:DW]) >= CW'(w_den);
        w_rem_re[0] = DENW'(w_n_re[NW-1:DW]);
        w_rem_im[0] = DENW'(w_n_im[NW-1:DW]);
        w_nl_re[0]  = w_n_re[DW-1:0];
        w_nl_im[0]  = w_n_im[DW-1:0];
        w_q_re[0]   = '0;
        w_q_im[0]   = '0;
        w_den_re[0] = w_den;
        w_den_im[0] = w_den;
        w_neg_re[0] = w_d_re[PW-1];
        w_neg_im[0] = w_d_im[PW-1];
    end

    // divider cell chain, two lanes
    t_side r_side [0:DW-1];

    for (genvar k = 0; k < DW; k++) begin : g_cell
        cac_div_cell #(.DEN_W(DENW), .Q_W(DW)) u_re (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem_re[k]),
            .i_nlow (w_nl_re[k]),
            .i_q    (w_q_re[k]),
            .i_den  (w_den_re[k]),
            .i_neg  (w_neg_re[k]),
            .i_ovf  (w_ovf_re[k]),
            .o_rem  (w_rem_re[k+1]),
            .o_nlow (w_nl_re[k+1]),
            .o_q    (w_q_re[k+1]),
            .o_den  (w_den_re[k+1]),
            .o_neg  (w_neg_re[k+1]),
            .o_ovf  (w_ovf_re[k+1])
        );
        cac_div_cell #(.DEN_W(DENW), .Q_W(DW)) u_im (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem_im[k]),
            .i_nlow (w_nl_im[k]),
            .i_q    (w_q_im[k]),
            .i_den  (w_den_im[k]),
            .i_neg  (w_neg_im[k]),
            .i_ovf  (w_ovf_im[k]),
            .o_rem  (w_rem_im[k+1]),
            .o_nlow (w_nl_im[k+1]),
            .o_q    (w_q_im[k+1]),
            .o_den  (w_den_im[k+1]),
            .o_neg  (w_neg_im[k+1]),
            .o_ovf  (w_ovf_im[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].vld <= 1'b0;
            end else if (w_en) begin
                r_side[k] <= (k == 0) ? w_side : r_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // output stage
    logic [DW:0]   w_qr, w_qi;
    logic [DW-1:0] w_fin_re, w_fin_im;
    t_status       w_fin_st;
    t_side         w_last;

    assign w_last = r_side[DW-1];

    always_comb begin
        w_qr = sat_q(w_q_re[DW], w_neg_re[DW], w_ovf_re[DW]);
        w_qi = sat_q(w_q_im[DW], w_neg_im[DW], w_ovf_im[DW]);
        if (!w_last.is_div) begin
            w_fin_re = w_last.re;
            w_fin_im = w_last.im;
            w_fin_st = w_last.st;
        end else if (w_last.dz) begin
            w_fin_re = '0;
            w_fin_im = '0;
            w_fin_st = ST_DZ;
        end else begin
            w_fin_re = w_qr[DW-1:0];
            w_fin_im = w_qi[DW-1:0];
            w_fin_st = (w_qr[DW] || w_qi[DW]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_p_vld <= w_last.vld;
            end
            if (r_sk_vld) begin
                if (m_axis_tready) begin
                    r_sk_vld <= 1'b0;
                end
            end else if (r_p_vld && !m_axis_tready) begin
                r_sk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_re  <= w_fin_re;
            r_p_im  <= w_fin_im;
            r_p_st  <= w_fin_st;
            r_sk_re <= r_p_re;
            r_sk_im <= r_p_im;
            r_sk_st <= r_p_st;
        end
    end

    assign m_axis_tvalid = r_sk_vld || r_p_vld;
    assign m_axis_tdata  = r_sk_vld ? OTW'({r_sk_im, r_sk_re}) : OTW'({r_p_im, r_p_re});
    assign m_axis_tuser  = r_sk_vld ? r_sk_st : r_p_st;

endmodule

// File: hdl/cac_checker.sv
`include "assert_macros.svh"

module cac_checker #(
    parameter int DATA_WIDTH = cac_pkg::DEF_DATA_WIDTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic [1:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]                        m_axis_tuser
);

    import cac_pkg::*;

    // a pending result must not vanish
    `CAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // the status code never takes the unused value
    `CAC_ASSERT_IMP(a_st_legal, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3)
    // divide by zero returns a zero result
    `CAC_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_DZ,
                    m_axis_tdata == '0)
    // input is refused only while a result waits for the consumer
    `CAC_ASSERT_IMP(a_rdy_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

endmodule

bind complex_arith_alu_unit cac_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cac_checker (.*);

// File: tb/sv/complex_arith_alu_unit_tb.sv
module complex_arith_alu_unit_tb;
    import cac_pkg::*;

    localparam int DW       = DEF_DATA_WIDTH;
    localparam int FB       = DEF_FRAC_BITS;
    localparam int LATENCY  = DW + 2;
    localparam int WDOG_MAX = 5000;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        t_status       st;
    } t_cplx_res;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [4*DW-1:0] s_axis_tdata = '0;
    logic [1:0]      s_axis_tuser = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [2*DW-1:0] m_axis_tdata;
    logic [1:0]      m_axis_tuser;

    t_cplx_res result_queue[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_sat = 0;
    int        n_dz = 0;
    int        idle_cycles = 0;
    bit        hold_off = 1'b0;
    bit        stall_bursty = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    complex_arith_alu_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Saturate an exact value to DW bits; flags clipping.
    function automatic logic [DW-1:0] clip_part(longint v, inout bit sat);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < -hi - 1) begin
            sat = 1'b1;
            return DW'(-hi - 1);
        end
        return v[DW-1:0];
    endfunction

    // (num << FB) / den, truncated toward zero, magnitude capped at 2^40.
    function automatic longint div_trunc(longint num, longint den);
        longint mag, q, r;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        r = mag % den;
        if (q > (longint'(1) << 40)) q = longint'(1) << 40;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
            if (q > (longint'(1) << 40)) q = longint'(1) << 40;
        end
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_cplx_res complex_op(t_func fn, logic [DW-1:0] a_in,
                                             logic [DW-1:0] b_in,
                                             logic [DW-1:0] c_in,
                                             logic [DW-1:0] d_in);
        longint    a, b, c, d, re, im, den;
        bit        sat;
        t_cplx_res res;
        a = longint'($signed(a_in));
        b = longint'($signed(b_in));
        c = longint'($signed(c_in));
        d = longint'($signed(d_in));
        sat = 1'b0;
        case (fn)
            FN_ADD: begin
                re = a + c;
                im = b + d;
            end
            FN_SUB: begin
                re = a - c;
                im = b - d;
            end
            FN_MUL: begin
                // >>> on a signed value floors
                re = (a * c - b * d) >>> FB;
                im = (a * d + b * c) >>> FB;
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    res.re = '0;
                    res.im = '0;
                    res.st = ST_DZ;
                    return res;
                end
                re = div_trunc(a * c + b * d, den);
                im = div_trunc(b * c - a * d, den);
            end
        endcase
        res.re = clip_part(re, sat);
        res.im = clip_part(im, sat);
        res.st = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic send_op(t_func fn, logic [DW-1:0] a, logic [DW-1:0] b,
                           logic [DW-1:0] c, logic [DW-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, c, b, a};
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        result_queue.push_back(complex_op(fn, a, b, c, d));
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random operand value biased toward the edges.
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(DW-1){1'b1}}};
            1: return {1'b1, {(DW-1){1'b0}}};
            2: return '0;
            3: return DW'($urandom_range(0, 1023)) - DW'(512);
            4: return {DW{1'b1}};
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        int   burst;
        t_func fn;
        logic [DW-1:0] c, d;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                s_axis_tvalid <= 1'b0;
                // idle gap before each burst, so tvalid is not driven twice at once
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 30);
            end
            fn = t_func'($urandom_range(0, 3));
            c = pick_operand();
            d = pick_operand();
            if (fn == FN_DIV && $urandom_range(0, 15) == 0) begin
                c = '0;
                d = '0;
            end
            send_op(fn, pick_operand(), pick_operand(), c, d);
            burst--;
        end
        release_bus();
    endtask

    task automatic wait_drained();
        while (result_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
        localparam logic [DW-1:0] MAXN = {1'b1, {(DW-1){1'b0}}};
        localparam logic [DW-1:0] ONE  = DW'(1) << FB;
        send_op(FN_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
        send_op(FN_ADD, MAXP, MAXN, MAXP, MAXN);
        send_op(FN_ADD, MAXP, MAXN, MAXN, MAXP);
        send_op(FN_SUB, MAXN, MAXP, MAXP, MAXN);
        send_op(FN_SUB, MAXP, MAXP, MAXP, MAXP);
        send_op(FN_MUL, ONE, ONE, ONE, -ONE);
        send_op(FN_MUL, MAXN, MAXN, MAXN, MAXN);
        send_op(FN_MUL, -16'sd1, 16'd1, 16'd1, 16'd1);
        send_op(FN_MUL, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
        send_op(FN_MUL, MAXP, MAXP, MAXP, MAXP);
        send_op(FN_DIV, ONE, ONE, 16'd0, 16'd0);
        send_op(FN_DIV, MAXN, MAXN, 16'd0, 16'd0);
        send_op(FN_DIV, ONE, 16'd0, ONE, 16'd0);
        send_op(FN_DIV, MAXP, MAXN, 16'd1, 16'd0);
        send_op(FN_DIV, MAXN, MAXN, 16'd0, 16'd1);
        send_op(FN_DIV, -16'sd3, 16'd7, 16'd5, -16'sd2);
        send_op(FN_DIV, 16'd1, 16'd1, MAXN, MAXN);
        send_op(FN_DIV, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        send_op(FN_SUB, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        release_bus();
    endtask

    // Receiver holds off while the sender keeps pushing; input must back up.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(60);
        join
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        send_random(400);
        test_backpressure();
        stall_bursty = 1'b0;
        send_random(440);
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d results: add/sub/mul/div, %0d saturated, %0d divide-by-zero,",
                 n_results, n_sat, n_dz);
        $display("with random source bursts, sink stalls and a long sink hold-off.");
        if (n_errors == 0 && result_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Sink stall pattern: full hold-off when requested, else bursty phase, then mostly ready.
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (stall_bursty) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= ($urandom_range(0, 15) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_cplx_res exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected transaction re=%h im=%h st=%0d", $time,
                         m_axis_tdata[DW-1:0], m_axis_tdata[2*DW-1:DW], m_axis_tuser);
                n_errors++;
            end else begin
                exp_res = result_queue.pop_front();
                if (exp_res.st == ST_SAT) n_sat++;
                if (exp_res.st == ST_DZ) n_dz++;
                if (m_axis_tdata[DW-1:0] !== exp_res.re) begin
                    $display("%0t: result_real expected %h actual %h", $time,
                             exp_res.re, m_axis_tdata[DW-1:0]);
                    n_errors++;
                end
                if (m_axis_tdata[2*DW-1:DW] !== exp_res.im) begin
                    $display("%0t: result_imag expected %h actual %h", $time,
                             exp_res.im, m_axis_tdata[2*DW-1:DW]);
                    n_errors++;
                end
                if (m_axis_tuser !== exp_res.st) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.st, m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: complex_arith_alu_unit.f
+incdir+hdl
hdl/cac_pkg.sv
hdl/cac_div_cell.sv
hdl/complex_arith_alu_unit.sv
hdl/cac_checker.sv
tb/sv/complex_arith_alu_unit_tb.sv
